### rtl/core/tile_map_pixel_source_lookup_defines.svh
// Assertion macros shared by the block's RTL.
`ifndef TILE_MAP_PIXEL_SOURCE_LOOKUP_DEFINES_SVH
`define TILE_MAP_PIXEL_SOURCE_LOOKUP_DEFINES_SVH
`ifndef SYNTHESIS
`define TMPSL_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tmpsl: forbidden condition seen");
`define TMPSL_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmpsl: implication violated");
`else
`define TMPSL_NEVER(lbl, clk, rst_n, expr)
`define TMPSL_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/tmpsl_pkg.sv
package tmpsl_pkg;

  localparam int TILE_PIXELS = 32;
  localparam int TILE_SHIFT  = $clog2(TILE_PIXELS);

  localparam int TILE_W     = 12;
  localparam int COLS_W     = 7;
  localparam int DIM_W      = 9;
  localparam int SCR_W      = 12;
  localparam int PIX_W      = 11;
  localparam int SCROLL_W   = 16;
  localparam int SRCX_W     = 11;
  localparam int SRCY_W     = 17;
  localparam int CELL_W     = 18;
  localparam int MX_W       = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int OUTQ_DEPTH = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 3'd0,
    CFG_MAP_HEIGHT = 3'd1,
    CFG_SHEET_COLS = 3'd2,
    CFG_SCREEN_W   = 3'd3,
    CFG_SCREEN_H   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  map_width;
    logic [DIM_W-1:0]  map_height;
    logic [COLS_W-1:0] sheet_cols;
    logic [SCR_W-1:0]  screen_w;
    logic [SCR_W-1:0]  screen_h;
  } tmpsl_cfg_t;

  localparam tmpsl_cfg_t CFG_RESET = '{
    map_width:  DIM_W'(1),
    map_height: DIM_W'(1),
    sheet_cols: COLS_W'(1),
    screen_w:   SCR_W'(640),
    screen_h:   SCR_W'(480)
  };

  typedef struct packed {
    logic                       op;
    logic [TILE_W-1:0]          cell_index;
    logic [TILE_W-1:0]          tile_value;
    logic [PIX_W-1:0]           pixel_x;
    logic [PIX_W-1:0]           pixel_y;
    logic signed [SCROLL_W-1:0] scroll_x;
    logic signed [SCROLL_W-1:0] scroll_y;
  } tmpsl_item_t;

  typedef struct packed {
    logic                  vld;
    logic                  op;
    logic                  miss;
    logic [CELL_W-1:0]     idx;
    logic [TILE_W-1:0]     tile;
    logic [TILE_SHIFT-1:0] fx;
    logic [TILE_SHIFT-1:0] fy;
  } tmpsl_cell_t;

  typedef struct packed {
    logic              hit;
    logic [SRCX_W-1:0] sheet_x;
    logic [SRCY_W-1:0] sheet_y;
  } tmpsl_res_t;

endpackage

### rtl/core/tmpsl_if.sv
interface tmpsl_in_if import tmpsl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [TILE_W-1:0]          cell_index;
  logic [TILE_W-1:0]          tile_value;
  logic [PIX_W-1:0]           pixel_x;
  logic [PIX_W-1:0]           pixel_y;
  logic signed [SCROLL_W-1:0] scroll_x;
  logic signed [SCROLL_W-1:0] scroll_y;

  modport source (
    output valid, operation, cell_index, tile_value, pixel_x, pixel_y, scroll_x, scroll_y,
    input  ready
  );
  modport sink (
    input  valid, operation, cell_index, tile_value, pixel_x, pixel_y, scroll_x, scroll_y,
    output ready
  );
endinterface

interface tmpsl_out_if import tmpsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SRCX_W-1:0] sheet_x;
  logic [SRCY_W-1:0] sheet_y;

  modport source (
    output valid, hit, sheet_x, sheet_y,
    input  ready
  );
  modport sink (
    input  valid, hit, sheet_x, sheet_y,
    output ready
  );
endinterface

### rtl/core/tmpsl_ram.sv
module tmpsl_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/tmpsl_addr.sv
module tmpsl_addr import tmpsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tmpsl_cfg_t  cfg,
  input  logic        in_vld,
  input  tmpsl_item_t in_item,
  output tmpsl_cell_t loc
);

  // stage 0: captured item
  logic        s0_vld_r;
  tmpsl_item_t s0_r;

  // stage 1: screen check, map pixel offset
  logic                    s1_vld_r, s1_vld_nxt;
  logic                    s1_op_r;
  logic                    s1_miss_r, s1_miss_nxt;
  logic [TILE_W-1:0]       s1_cidx_r;
  logic [TILE_W-1:0]       s1_tval_r;
  logic signed [MX_W-1:0]  s1_mx_r, s1_mx_nxt;
  logic signed [MX_W-1:0]  s1_my_r, s1_my_nxt;

  // stage 2: map bounds, tile coordinates
  logic                    s2_vld_r;
  logic                    s2_op_r;
  logic                    s2_miss_r, s2_miss_nxt;
  logic [TILE_W-1:0]       s2_cidx_r;
  logic [TILE_W-1:0]       s2_tval_r;
  logic [DIM_W-1:0]        s2_col_r;
  logic [DIM_W-1:0]        s2_row_r;
  logic [TILE_SHIFT-1:0]   s2_fx_r;
  logic [TILE_SHIFT-1:0]   s2_fy_r;

  logic [MX_W-2:0]         wlim;
  logic [MX_W-2:0]         hlim;

  // stage 3: cell index
  tmpsl_cell_t cell_r, cell_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_vld;
    end
    s0_r <= in_item;
  end

  assign s1_vld_nxt = s0_vld_r;

  always_comb begin
    s1_miss_nxt = (s0_r.op == OP_WRITE) ||
                  ({1'b0, s0_r.pixel_x} >= cfg.screen_w) ||
                  ({1'b0, s0_r.pixel_y} >= cfg.screen_h);
    s1_mx_nxt = $signed({{(MX_W-PIX_W){1'b0}}, s0_r.pixel_x}) -
                $signed({{(MX_W-SCROLL_W){s0_r.scroll_x[SCROLL_W-1]}}, s0_r.scroll_x});
    s1_my_nxt = $signed({{(MX_W-PIX_W){1'b0}}, s0_r.pixel_y}) -
                $signed({{(MX_W-SCROLL_W){s0_r.scroll_y[SCROLL_W-1]}}, s0_r.scroll_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    s1_op_r   <= s0_r.op;
    s1_miss_r <= s1_miss_nxt;
    s1_cidx_r <= s0_r.cell_index;
    s1_tval_r <= s0_r.tile_value;
    s1_mx_r   <= s1_mx_nxt;
    s1_my_r   <= s1_my_nxt;
  end

  assign wlim = (MX_W-1)'({cfg.map_width, {TILE_SHIFT{1'b0}}});
  assign hlim = (MX_W-1)'({cfg.map_height, {TILE_SHIFT{1'b0}}});

  always_comb begin
    s2_miss_nxt = s1_miss_r || s1_mx_r[MX_W-1] || s1_my_r[MX_W-1] ||
                  (s1_mx_r[MX_W-2:0] >= wlim) || (s1_my_r[MX_W-2:0] >= hlim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_op_r   <= s1_op_r;
    s2_miss_r <= s2_miss_nxt;
    s2_cidx_r <= s1_cidx_r;
    s2_tval_r <= s1_tval_r;
    s2_col_r  <= s1_mx_r[TILE_SHIFT +: DIM_W];
    s2_row_r  <= s1_my_r[TILE_SHIFT +: DIM_W];
    s2_fx_r   <= s1_mx_r[TILE_SHIFT-1:0];
    s2_fy_r   <= s1_my_r[TILE_SHIFT-1:0];
  end

  always_comb begin
    cell_nxt.vld  = s2_vld_r;
    cell_nxt.op   = s2_op_r;
    cell_nxt.miss = s2_miss_r;
    cell_nxt.tile = s2_tval_r;
    cell_nxt.fx   = s2_fx_r;
    cell_nxt.fy   = s2_fy_r;
    if (s2_op_r == OP_WRITE) begin
      cell_nxt.idx = CELL_W'(s2_cidx_r);
    end else begin
      cell_nxt.idx = CELL_W'(s2_row_r * cfg.map_width) + CELL_W'(s2_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= cell_nxt.vld;
    end
    cell_r.op   <= cell_nxt.op;
    cell_r.miss <= cell_nxt.miss;
    cell_r.idx  <= cell_nxt.idx;
    cell_r.tile <= cell_nxt.tile;
    cell_r.fx   <= cell_nxt.fx;
    cell_r.fy   <= cell_nxt.fy;
  end

  assign loc = cell_r;

endmodule

### rtl/core/tmpsl_div.sv
`include "tile_map_pixel_source_lookup_defines.svh"

module tmpsl_div #(
  parameter int DW = 12,
  parameter int VW = 7,
  parameter int TW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [DW-1:0] in_num,
  input  logic [VW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [DW-1:0] out_quo,
  output logic [VW-1:0] out_rem,
  output logic [TW-1:0] out_tag
);

  // one quotient bit per stage, MSB first
  logic          vld_r [DW];
  logic [VW-1:0] rem_r [DW];
  logic [DW-1:0] quo_r [DW];
  logic [DW-1:0] num_r [DW];
  logic [TW-1:0] tag_r [DW];

  logic          p_vld [DW];
  logic [VW-1:0] p_rem [DW];
  logic [DW-1:0] p_quo [DW];
  logic [DW-1:0] p_num [DW];
  logic [TW-1:0] p_tag [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW:0]   trial;
    logic          ge;
    logic [VW:0]   diff;
    logic [VW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign p_vld[k] = in_vld;
      assign p_rem[k] = '0;
      assign p_quo[k] = '0;
      assign p_num[k] = in_num;
      assign p_tag[k] = in_tag;
    end else begin : g_next
      assign p_vld[k] = vld_r[k-1];
      assign p_rem[k] = rem_r[k-1];
      assign p_quo[k] = quo_r[k-1];
      assign p_num[k] = num_r[k-1];
      assign p_tag[k] = tag_r[k-1];
    end

    assign trial   = {p_rem[k], p_num[k][DW-1]};
    assign ge      = trial >= {1'b0, in_den};
    assign diff    = trial - {1'b0, in_den};
    assign rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= p_vld[k];
      end
      rem_r[k] <= rem_nxt;
      quo_r[k] <= {p_quo[k][DW-2:0], ge};
      num_r[k] <= {p_num[k][DW-2:0], 1'b0};
      tag_r[k] <= p_tag[k];
    end
  end

  assign out_vld = vld_r[DW-1];
  assign out_quo = quo_r[DW-1];
  assign out_rem = rem_r[DW-1];
  assign out_tag = tag_r[DW-1];

  `TMPSL_NEVER(a_rem_below_den, clk, rst_n, out_vld && (out_rem >= in_den))

endmodule

### rtl/core/tmpsl_fifo.sv
`include "tile_map_pixel_source_lookup_defines.svh"

module tmpsl_fifo import tmpsl_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  output logic       can_acc,
  input  logic       push,
  input  tmpsl_res_t push_data,
  output logic       pop_vld,
  input  logic       pop,
  output tmpsl_res_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // credit_r: items accepted upstream and not yet popped
  logic [CW-1:0] credit_r, credit_nxt;
  logic [CW-1:0] stored_r, stored_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  tmpsl_res_t    mem_r [DEPTH];

  always_comb begin
    credit_nxt = credit_r;
    if (acc && !pop) begin
      credit_nxt = credit_r + 1'b1;
    end else if (!acc && pop) begin
      credit_nxt = credit_r - 1'b1;
    end
    stored_nxt = stored_r;
    if (push && !pop) begin
      stored_nxt = stored_r + 1'b1;
    end else if (!push && pop) begin
      stored_nxt = stored_r - 1'b1;
    end
    wr_ptr_nxt = wr_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      stored_r <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      credit_r <= credit_nxt;
      stored_r <= stored_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign can_acc  = credit_r != CW'(DEPTH);
  assign pop_vld  = stored_r != '0;
  assign pop_data = mem_r[rd_ptr_r];

  `TMPSL_NEVER(a_no_overflow, clk, rst_n, push && !pop && (stored_r == CW'(DEPTH)))
  `TMPSL_NEVER(a_stored_le_credit, clk, rst_n, stored_r > credit_r)

endmodule

### rtl/core/tile_map_pixel_source_lookup.sv
// Pipeline from the accepting clock edge to out valid: 4 address stages, one map read,
// 12 stages of the pipelined tile-to-sheet divider, then the result queue.
// Throughput: one item per cycle; a 32-entry result queue with credit counting sets
// how many items may be outstanding before in ready drops.
// Reset (rst_n low, synchronous): pipeline and queue empty, registers at defaults;
// map contents are kept and are undefined until written.
`include "tile_map_pixel_source_lookup_defines.svh"

module tile_map_pixel_source_lookup import tmpsl_pkg::*; #(
  parameter int MAP_CELLS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tmpsl_in_if.sink              in_ch,
  tmpsl_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAP_CELLS);
  localparam logic [CELL_W-1:0] CELL_LIM = CELL_W'(MAP_CELLS);
  localparam int TAG_W = 1 + 2 * TILE_SHIFT;

  tmpsl_cfg_t  cfg_r, cfg_nxt;
  tmpsl_item_t item;
  tmpsl_cell_t loc;
  logic        in_xfer;
  logic        out_xfer;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [TILE_W-1:0] ram_rdata;

  logic                  s4_vld_r;
  logic                  s4_miss_r;
  logic [TILE_SHIFT-1:0] s4_fx_r;
  logic [TILE_SHIFT-1:0] s4_fy_r;

  logic              t_miss;
  logic [TILE_W-1:0] t_num;
  logic [COLS_W-1:0] cols_eff;
  logic [TAG_W-1:0]  div_tag_in;

  logic              div_vld;
  logic [TILE_W-1:0] div_quo;
  logic [COLS_W-1:0] div_rem;
  logic [TAG_W-1:0]  div_tag;

  tmpsl_res_t res;
  tmpsl_res_t q_data;
  logic       q_vld;
  logic       can_acc;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAP_WIDTH:  cfg_nxt.map_width  = cfg_wdata[DIM_W-1:0];
        CFG_MAP_HEIGHT: cfg_nxt.map_height = cfg_wdata[DIM_W-1:0];
        CFG_SHEET_COLS: cfg_nxt.sheet_cols = cfg_wdata[COLS_W-1:0];
        CFG_SCREEN_W:   cfg_nxt.screen_w   = cfg_wdata[SCR_W-1:0];
        CFG_SCREEN_H:   cfg_nxt.screen_h   = cfg_wdata[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ch.ready = can_acc;
  assign in_xfer     = in_ch.valid && can_acc;
  assign out_xfer    = q_vld && out_ch.ready;

  always_comb begin
    item.op         = in_ch.operation;
    item.cell_index = in_ch.cell_index;
    item.tile_value = in_ch.tile_value;
    item.pixel_x    = in_ch.pixel_x;
    item.pixel_y    = in_ch.pixel_y;
    item.scroll_x   = in_ch.scroll_x;
    item.scroll_y   = in_ch.scroll_y;
  end

  tmpsl_addr u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_vld  (in_xfer),
    .in_item (item),
    .loc     (loc)
  );

  // only queries that land on the map read the store
  assign ram_we   = loc.vld && (loc.op == OP_WRITE) && (loc.idx < CELL_LIM);
  assign ram_re   = loc.vld && (loc.op == OP_QUERY) && !loc.miss && (loc.idx < CELL_LIM);
  assign ram_addr = loc.idx[AW-1:0];

  tmpsl_ram #(
    .WIDTH (TILE_W),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (loc.tile),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= loc.vld;
    end
    s4_miss_r <= loc.miss || (loc.idx >= CELL_LIM);
    s4_fx_r   <= loc.fx;
    s4_fy_r   <= loc.fy;
  end

  assign t_miss     = s4_miss_r || (ram_rdata == '0);
  assign t_num      = t_miss ? '0 : ram_rdata - 1'b1;
  assign cols_eff   = (cfg_r.sheet_cols == '0) ? COLS_W'(1) : cfg_r.sheet_cols;
  assign div_tag_in = {t_miss, s4_fx_r, s4_fy_r};

  tmpsl_div #(
    .DW (TILE_W),
    .VW (COLS_W),
    .TW (TAG_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s4_vld_r),
    .in_num  (t_num),
    .in_den  (cols_eff),
    .in_tag  (div_tag_in),
    .out_vld (div_vld),
    .out_quo (div_quo),
    .out_rem (div_rem),
    .out_tag (div_tag)
  );

  always_comb begin
    res.hit = !div_tag[TAG_W-1];
    if (res.hit) begin
      res.sheet_x = SRCX_W'({div_rem, div_tag[2*TILE_SHIFT-1:TILE_SHIFT]});
      res.sheet_y = SRCY_W'({div_quo, div_tag[TILE_SHIFT-1:0]});
    end else begin
      res.sheet_x = '0;
      res.sheet_y = '0;
    end
  end

  tmpsl_fifo #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_xfer),
    .can_acc   (can_acc),
    .push      (div_vld),
    .push_data (res),
    .pop_vld   (q_vld),
    .pop       (out_xfer),
    .pop_data  (q_data)
  );

  assign out_ch.valid   = q_vld;
  assign out_ch.hit     = q_data.hit;
  assign out_ch.sheet_x = q_data.sheet_x;
  assign out_ch.sheet_y = q_data.sheet_y;

  `TMPSL_IMPLY(a_miss_zero, clk, rst_n, q_vld && !q_data.hit, q_data == '0)
  `TMPSL_IMPLY(a_div_latency, clk, rst_n, div_vld, $past(s4_vld_r, TILE_W))
  `TMPSL_NEVER(a_ram_one_access, clk, rst_n, ram_we && ram_re)

endmodule
